FILE: design/fbfla_pkg.sv
// Shared types and codes for the fixed block free list allocator.
// No dependencies; imported by every module of the block.
`default_nettype none
package fbfla_pkg;

  localparam int unsigned IdxW    = 8;
  localparam int unsigned CountW  = 9;
  localparam int unsigned BytesW  = 13;
  localparam int unsigned OffsetW = 20;
  localparam int unsigned TotalW  = 32;
  localparam int unsigned CfgW    = 13;

  localparam logic [BytesW-1:0] MinBlockBytes   = 13'd4;
  localparam logic [BytesW-1:0] MaxBlockBytes   = 13'd4096;
  localparam logic [BytesW-1:0] ResetBlockBytes = 13'd16;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic {
    CFG_POOL_BLOCKS = 1'b0,
    CFG_BLOCK_BYTES = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_ALLOC = 2'd0,
    STAT_FREED = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_BAD   = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage
`default_nettype wire

FILE: design/fixed_block_free_list_allocator_unit.sv
// Top level of the fixed block free list allocator.
// Instantiates fbfla_ctrl and fbfla_datapath; uses fbfla_pkg.
//
// Each request is sequenced as follows: start_i is taken while busy_o is low, the
// head's next link is read from the registered next-link memory in the cycle
// after, and the result beat appears on the result ports for one cycle marked
// by done_o; a new start_i is taken in that same cycle. The receiver cannot
// stall, so capture every beat on done_o. free_blocks_o, alloc_total_o and
// free_total_o always show the current counts. Writing pool_blocks relinks
// the pool at once, with no clearing pass; write configuration only when idle.
`default_nettype none
module fixed_block_free_list_allocator_unit #(
  parameter int unsigned POOL_BLOCKS = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          mode_i,
  input  wire logic [fbfla_pkg::IdxW-1:0]    block_index_i,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [fbfla_pkg::CfgW-1:0]    cfg_data_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [fbfla_pkg::IdxW-1:0]         granted_index_o,
  output logic [fbfla_pkg::OffsetW-1:0]      byte_offset_o,
  output logic [fbfla_pkg::CountW-1:0]       free_blocks_o,
  output logic [fbfla_pkg::TotalW-1:0]       alloc_total_o,
  output logic [fbfla_pkg::TotalW-1:0]       free_total_o
);
  import fbfla_pkg::*;

  localparam int unsigned PoolCap = (POOL_BLOCKS < 256) ? POOL_BLOCKS : 256;

  cmd_t cmd;

  fbfla_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  fbfla_datapath #(
    .PoolCap (PoolCap)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .mode_i          (mode_i),
    .block_index_i   (block_index_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .byte_offset_o   (byte_offset_o),
    .free_blocks_o   (free_blocks_o),
    .alloc_total_o   (alloc_total_o),
    .free_total_o    (free_total_o)
  );

endmodule
`default_nettype wire

FILE: design/fbfla_ctrl.sv
// Controller of the fixed block free list allocator: sequences one request.
// Depends on fbfla_pkg for the state type and the command struct.
`default_nettype none
module fbfla_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output fbfla_pkg::cmd_t    cmd_o,
  output logic               busy_o
);
  import fbfla_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = start_i;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        busy_o     = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/fbfla_datapath.sv
// Datapath of the fixed block free list allocator: next-link memory, list
// head, counters, configuration registers and result registers. Uses fbfla_pkg.
`default_nettype none
module fbfla_datapath #(
  parameter int unsigned PoolCap = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fbfla_pkg::cmd_t               cmd_i,
  input  wire logic                          mode_i,
  input  wire logic [fbfla_pkg::IdxW-1:0]    block_index_i,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [fbfla_pkg::CfgW-1:0]    cfg_data_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [fbfla_pkg::IdxW-1:0]         granted_index_o,
  output logic [fbfla_pkg::OffsetW-1:0]      byte_offset_o,
  output logic [fbfla_pkg::CountW-1:0]       free_blocks_o,
  output logic [fbfla_pkg::TotalW-1:0]       alloc_total_o,
  output logic [fbfla_pkg::TotalW-1:0]       free_total_o
);
  import fbfla_pkg::*;

  localparam int unsigned AddrW = (PoolCap > 1) ? $clog2(PoolCap) : 1;
  localparam logic [CountW-1:0] CapCount = CountW'(PoolCap);
  localparam int unsigned ProdW = IdxW + BytesW;

  logic [AddrW-1:0] link_mem [PoolCap];
  logic [PoolCap-1:0] link_vld_q;

  logic [CountW-1:0] pool_q;
  logic [BytesW-1:0] bytes_q;
  logic [AddrW-1:0]  head_q, head_d;
  logic [CountW-1:0] free_cnt_q, free_cnt_d;
  logic [TotalW-1:0] alloc_cnt_q, alloc_cnt_d;
  logic [TotalW-1:0] free_tot_q, free_tot_d;

  logic              mode_q;
  logic [IdxW-1:0]   idx_q;
  logic [AddrW-1:0]  rdata_q;
  logic              rvld_q;
  logic [AddrW-1:0]  raddr_q;

  logic              done_q;
  logic [1:0]        status_q, status_d;
  logic [IdxW-1:0]   granted_q, granted_d;
  logic [OffsetW-1:0] offset_q, offset_d;

  logic [CountW-1:0] pool_wr;
  logic [BytesW-1:0] bytes_wr;
  logic [AddrW-1:0]  link_rd;
  logic [CountW-1:0] raddr_inc;
  logic [ProdW-1:0]  product;
  logic              push_ok;
  logic              relink;

  always_comb begin
    pool_wr = cfg_data_i[CountW-1:0];
    if (pool_wr == '0) begin
      pool_wr = CountW'(1);
    end else if (pool_wr > CapCount) begin
      pool_wr = CapCount;
    end
    bytes_wr = cfg_data_i[BytesW-1:0];
    if (bytes_wr < MinBlockBytes) begin
      bytes_wr = MinBlockBytes;
    end else if (bytes_wr > MaxBlockBytes) begin
      bytes_wr = MaxBlockBytes;
    end
  end

  assign relink = cfg_we_i && (cfg_idx_i == CFG_POOL_BLOCKS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q  <= CapCount;
      bytes_q <= ResetBlockBytes;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_BLOCKS: pool_q  <= pool_wr;
        CFG_BLOCK_BYTES: bytes_q <= bytes_wr;
        default: begin
          pool_q <= pool_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      idx_q   <= block_index_i;
      rdata_q <= link_mem[head_q];
      raddr_q <= head_q;
    end
    if (cmd_i.exec && (mode_q == MODE_FREE) && push_ok) begin
      link_mem[idx_q[AddrW-1:0]] <= head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else if (cmd_i.capture) begin
      rvld_q <= link_vld_q[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (relink) begin
      link_vld_q <= '0;
    end else if (cmd_i.exec && (mode_q == MODE_FREE) && push_ok) begin
      link_vld_q[idx_q[AddrW-1:0]] <= 1'b1;
    end
  end

  assign raddr_inc = CountW'(raddr_q) + CountW'(1);
  assign link_rd   = rvld_q ? rdata_q
                   : ((raddr_inc < pool_q) ? raddr_inc[AddrW-1:0] : '0);
  assign push_ok   = (CountW'(idx_q) < pool_q) && (free_cnt_q < pool_q);
  assign product   = ProdW'(IdxW'(head_q)) * ProdW'(bytes_q);

  always_comb begin
    head_d      = head_q;
    free_cnt_d  = free_cnt_q;
    alloc_cnt_d = alloc_cnt_q;
    free_tot_d  = free_tot_q;
    status_d    = status_q;
    granted_d   = granted_q;
    offset_d    = offset_q;
    if (relink) begin
      head_d     = '0;
      free_cnt_d = pool_wr;
    end else if (cmd_i.exec) begin
      granted_d = '0;
      offset_d  = '0;
      if (mode_q == MODE_ALLOC) begin
        if (free_cnt_q == '0) begin
          status_d = STAT_EMPTY;
        end else begin
          status_d    = STAT_ALLOC;
          granted_d   = IdxW'(head_q);
          offset_d    = product[OffsetW-1:0];
          head_d      = link_rd;
          free_cnt_d  = free_cnt_q - CountW'(1);
          alloc_cnt_d = alloc_cnt_q + TotalW'(1);
        end
      end else begin
        if (push_ok) begin
          status_d   = STAT_FREED;
          head_d     = idx_q[AddrW-1:0];
          free_cnt_d = free_cnt_q + CountW'(1);
          free_tot_d = free_tot_q + TotalW'(1);
        end else begin
          status_d = STAT_BAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      free_cnt_q  <= CapCount;
      alloc_cnt_q <= '0;
      free_tot_q  <= '0;
      done_q      <= 1'b0;
    end else begin
      head_q      <= head_d;
      free_cnt_q  <= free_cnt_d;
      alloc_cnt_q <= alloc_cnt_d;
      free_tot_q  <= free_tot_d;
      done_q      <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    granted_q <= granted_d;
    offset_q  <= offset_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_q;
  assign byte_offset_o   = offset_q;
  assign free_blocks_o   = free_cnt_q;
  assign alloc_total_o   = alloc_cnt_q;
  assign free_total_o    = free_tot_q;

endmodule
`default_nettype wire

FILE: test/fbfla_checker.sv
// Checker for the fixed block free list allocator: predicts each result beat
// from the accepted requests and register writes, then compares field by field.
// Depends on fbfla_pkg; instantiated by fixed_block_free_list_allocator_unit_test.
`default_nettype none
module fbfla_checker
  import fbfla_pkg::*;
#(
  parameter int unsigned POOL_BLOCKS = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 busy_i,
  input  wire logic                 mode_i,
  input  wire logic [IdxW-1:0]      block_index_i,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_idx_i,
  input  wire logic [CfgW-1:0]      cfg_data_i,
  input  wire logic                 done_i,
  input  wire logic [1:0]           status_i,
  input  wire logic [IdxW-1:0]      granted_index_i,
  input  wire logic [OffsetW-1:0]   byte_offset_i,
  input  wire logic [CountW-1:0]    free_blocks_i,
  input  wire logic [TotalW-1:0]    alloc_total_i,
  input  wire logic [TotalW-1:0]    free_total_i,
  output int unsigned               pending_o,
  output int unsigned               error_count_o
);

  localparam int unsigned PoolCap = (POOL_BLOCKS < 256) ? POOL_BLOCKS : 256;

  typedef struct packed {
    status_e              status;
    logic [IdxW-1:0]      granted;
    logic [OffsetW-1:0]   offset;
    logic [CountW-1:0]    free_blocks;
    logic [TotalW-1:0]    alloc_total;
    logic [TotalW-1:0]    free_total;
  } grant_beat_t;

  grant_beat_t       predicted_beats[$];
  logic [IdxW-1:0]   next_link [256];
  logic [IdxW-1:0]   list_head;
  logic [CountW-1:0] free_count;
  logic [TotalW-1:0] grants_made;
  logic [TotalW-1:0] frees_taken;
  logic [CountW-1:0] pool_reg;
  logic [BytesW-1:0] bytes_reg;

  function automatic int unsigned live_pool();
    int unsigned n;
    n = pool_reg;
    if (n < 1) n = 1;
    if (n > PoolCap) n = PoolCap;
    return n;
  endfunction

  function automatic int unsigned live_bytes();
    int unsigned b;
    b = bytes_reg;
    if (b < MinBlockBytes) b = MinBlockBytes;
    if (b > MaxBlockBytes) b = MaxBlockBytes;
    return b;
  endfunction

  task automatic relink_pool();
    int unsigned n;
    n = live_pool();
    for (int i = 0; i < 256; i++) begin
      next_link[i] = (i + 1 < n) ? IdxW'(i + 1) : '0;
    end
    list_head  = '0;
    free_count = CountW'(n);
  endtask

  task automatic predict_request(input mode_e m, input logic [IdxW-1:0] idx);
    grant_beat_t beat;
    int unsigned n;
    n    = live_pool();
    beat = '0;
    if (m == MODE_ALLOC) begin
      if (free_count == 0) begin
        beat.status = STAT_EMPTY;
      end else begin
        beat.granted = list_head;
        beat.offset  = OffsetW'(beat.granted * live_bytes());
        beat.status  = STAT_ALLOC;
        list_head    = next_link[list_head];
        free_count   = free_count - 1'b1;
        grants_made  = grants_made + 1'b1;
      end
    end else begin
      if (idx >= n || free_count >= n) begin
        beat.status = STAT_BAD;
      end else begin
        next_link[idx] = list_head;
        list_head      = idx;
        free_count     = free_count + 1'b1;
        frees_taken    = frees_taken + 1'b1;
        beat.status    = STAT_FREED;
      end
    end
    beat.free_blocks = free_count;
    beat.alloc_total = grants_made;
    beat.free_total  = frees_taken;
    predicted_beats.push_back(beat);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count_o++;
    end
  endtask

  task automatic compare_beat();
    grant_beat_t want;
    if (predicted_beats.size() == 0) begin
      $error("result beat with no request outstanding");
      error_count_o++;
    end else begin
      want = predicted_beats.pop_front();
      check_field("status", 32'(want.status), 32'(status_i));
      check_field("granted_index", 32'(want.granted), 32'(granted_index_i));
      check_field("byte_offset", 32'(want.offset), 32'(byte_offset_i));
      check_field("free_blocks", 32'(want.free_blocks), 32'(free_blocks_i));
      check_field("alloc_total", want.alloc_total, alloc_total_i);
      check_field("free_total", want.free_total, free_total_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      predicted_beats.delete();
      pool_reg      = 9'd256;
      bytes_reg     = ResetBlockBytes;
      grants_made   = '0;
      frees_taken   = '0;
      error_count_o = 0;
      relink_pool();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_POOL_BLOCKS) begin
          pool_reg = cfg_data_i[CountW-1:0];
          relink_pool();
        end else begin
          bytes_reg = cfg_data_i[BytesW-1:0];
        end
      end
      if (done_i) compare_beat();
      if (start_i && !busy_i) predict_request(mode_e'(mode_i), block_index_i);
    end
    pending_o = predicted_beats.size();
  end

endmodule
`default_nettype wire

FILE: test/fixed_block_free_list_allocator_unit_test.sv
// Testbench top for the fixed block free list allocator: drives directed and
// random allocate/free requests and register writes, and gives the verdict.
// Depends on fbfla_pkg, fixed_block_free_list_allocator_unit and fbfla_checker.
`default_nettype none
module fixed_block_free_list_allocator_unit_test;
  import fbfla_pkg::*;

  localparam int unsigned PoolBlocks = 256;
  localparam int unsigned StallLimit = 1000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                mode;
  logic [IdxW-1:0]     block_index;
  logic                cfg_we;
  logic                cfg_idx;
  logic [CfgW-1:0]     cfg_data;
  logic                done;
  logic [1:0]          status;
  logic [IdxW-1:0]     granted_index;
  logic [OffsetW-1:0]  byte_offset;
  logic [CountW-1:0]   free_blocks;
  logic [TotalW-1:0]   alloc_total;
  logic [TotalW-1:0]   free_total;
  int unsigned         beats_pending;
  int unsigned         mismatches;
  int unsigned         stall_cycles = 0;
  int unsigned         pool_now;

  always #10 clk = ~clk;

  fixed_block_free_list_allocator_unit #(
    .POOL_BLOCKS(PoolBlocks)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .mode_i         (mode),
    .block_index_i  (block_index),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .done_o         (done),
    .status_o       (status),
    .granted_index_o(granted_index),
    .byte_offset_o  (byte_offset),
    .free_blocks_o  (free_blocks),
    .alloc_total_o  (alloc_total),
    .free_total_o   (free_total)
  );

  fbfla_checker #(
    .POOL_BLOCKS(PoolBlocks)
  ) checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .mode_i         (mode),
    .block_index_i  (block_index),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .done_i         (done),
    .status_i       (status),
    .granted_index_i(granted_index),
    .byte_offset_i  (byte_offset),
    .free_blocks_i  (free_blocks),
    .alloc_total_i  (alloc_total),
    .free_total_i   (free_total),
    .pending_o      (beats_pending),
    .error_count_o  (mismatches)
  );

  function automatic int unsigned clamp_pool(input int unsigned v);
    int unsigned n;
    n = v & 9'h1FF;
    if (n < 1) n = 1;
    if (n > PoolBlocks) n = PoolBlocks;
    return n;
  endfunction

  task automatic issue(input mode_e m, input logic [IdxW-1:0] idx, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    mode        <= m;
    block_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start and hold until every beat has come back
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (beats_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e r, input logic [CfgW-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (r == CFG_POOL_BLOCKS) pool_now = clamp_pool(v);
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned pool_val,
                              input int unsigned bytes_val, input int unsigned alloc_pct,
                              input int unsigned max_gap);
    mode_e           m;
    logic [IdxW-1:0] idx;
    settle();
    write_reg(CFG_POOL_BLOCKS, CfgW'(pool_val));
    write_reg(CFG_BLOCK_BYTES, CfgW'(bytes_val));
    for (int unsigned k = 0; k < count; k++) begin
      if (k == count / 2) settle();
      m   = ($urandom_range(1, 100) <= alloc_pct) ? MODE_ALLOC : MODE_FREE;
      idx = ($urandom_range(0, 3) != 0) ? IdxW'($urandom_range(0, pool_now - 1))
                                        : IdxW'($urandom_range(0, 255));
      issue(m, idx, $urandom_range(0, max_gap));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    mode        = MODE_ALLOC;
    block_index = '0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_POOL_BLOCKS;
    cfg_data    = '0;
    pool_now    = PoolBlocks;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(MODE_ALLOC, 8'hFF, 0);
    issue(MODE_ALLOC, 8'h00, 0);
    issue(MODE_ALLOC, 8'hAA, 3);
    issue(MODE_FREE, 8'd1, 0);
    issue(MODE_FREE, 8'd1, 5);
    issue(MODE_ALLOC, 8'h00, 0);
    issue(MODE_ALLOC, 8'h00, 0);
    issue(MODE_FREE, 8'hFF, 0);
    settle();
    write_reg(CFG_BLOCK_BYTES, 13'h1FFF);
    issue(MODE_ALLOC, 8'h00, 1);
    settle();
    write_reg(CFG_POOL_BLOCKS, 13'd0);
    write_reg(CFG_BLOCK_BYTES, 13'd0);
    issue(MODE_ALLOC, 8'h00, 0);
    issue(MODE_ALLOC, 8'h00, 0);
    issue(MODE_FREE, 8'd0, 2);
    issue(MODE_FREE, 8'd0, 0);
    issue(MODE_ALLOC, 8'h00, 0);
    issue(MODE_FREE, 8'hFF, 0);
    issue(MODE_FREE, 8'd1, 0);
    issue(MODE_FREE, 8'd0, 0);
    settle();
    write_reg(CFG_POOL_BLOCKS, 13'd511);
    write_reg(CFG_BLOCK_BYTES, 13'd4096);
    issue(MODE_FREE, 8'h55, 0);

    random_phase(48, 4, $urandom_range(0, 8191), 50, 18);
    random_phase(48, 1, 4, 50, 0);
    random_phase(48, 16, 4096, 70, 18);
    random_phase(48, 16, $urandom_range(0, 8191), 30, 4);
    random_phase(48, 256, $urandom_range(0, 8191), 85, 18);
    random_phase(48, $urandom_range(0, 511), 8191, 55, 0);
    random_phase(48, 0, 0, 50, 18);
    random_phase(48, $urandom_range(2, 12), 3, 50, 18);

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
